[design/fos_pkg.sv]
`default_nettype none
package fos_pkg;

  // Default queue capacity
  localparam int DEPTH_DEF = 64;

  // Divisor applied to wait figures
  localparam int WAIT_UNIT = 1000;

  // Reciprocal of WAIT_UNIT scaled by 2**WAIT_SHIFT, rounded up; exact for any 32-bit word
  localparam int WAIT_RECIP = 274877907;
  localparam int WAIT_SHIFT = 38;

  // Request codes
  localparam logic [1:0] REQ_PUSH  = 2'd0;
  localparam logic [1:0] REQ_POP   = 2'd1;
  localparam logic [1:0] REQ_STATS = 2'd2;
  localparam logic [1:0] REQ_WAIT  = 2'd3;

  // Status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_POP_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  // One request word
  typedef struct packed {
    logic [1:0]  req_type;
    logic [30:0] push_value;
    logic [31:0] prev_mean_wait;
    logic [30:0] max_wait_floor;
    logic [30:0] now_time;
  } req_t;

  // One result word
  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] popped_value;
    logic [6:0]  entry_count;
    logic [30:0] max_value;
    logic [30:0] mean_value;
    logic [30:0] median_value;
    logic [21:0] max_wait_units;
    logic [22:0] mean_wait_units;
  } res_t;

endpackage
`default_nettype wire

[design/fifo_with_order_statistics.sv]
// Bounded queue of timestamps with statistics requests.
// Request side: drive the request fields with push high; a word is taken on a
// clock edge where push is high and full is low. A two-word request queue sits
// in front, so a few requests may be posted while the engine is busy.
// Result side: while empty is low the oldest result is on the result ports;
// raise pop to take it. A two-word result queue decouples the receiver: a
// stalled receiver holds results there, and the engine takes no new request
// while that queue is full or a result is being written into it. Every request
// gives exactly one result, in order. A push, and any request on an empty queue
// except a wait query, is answered straight from the idle state; a pop reads the
// oldest entry; a contents query sweeps the entries for sum and maximum, divides
// the sum by the entry count, then finds the median by rank count, one sweep of
// all entries per entry; a wait query sweeps the waits, divides their sum by the
// entry count, averages it with the previous mean wait and scales it.
// The time each request takes is set by the single read port of the entry memory,
// one entry a cycle, by the one-bit-per-cycle divider for the division by the entry
// count, and by a reciprocal multiply for the wait unit. One request is worked at a
// time. Reset (rst, synchronous) empties both queues and the store; no
// clearing pass is needed.
`default_nettype none
module fifo_with_order_statistics #(
  parameter int DEPTH = fos_pkg::DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [1:0]  req_type,
  input  wire logic [30:0] push_value,
  input  wire logic signed [31:0] prev_mean_wait,
  input  wire logic [30:0] max_wait_floor,
  input  wire logic [30:0] now_time,
  output logic             empty,
  input  wire logic        pop,
  output logic [1:0]       status,
  output logic signed [31:0] popped_value,
  output logic [6:0]       entry_count,
  output logic [30:0]      max_value,
  output logic [30:0]      mean_value,
  output logic [30:0]      median_value,
  output logic [21:0]      max_wait_units,
  output logic signed [22:0] mean_wait_units
);

  fos_pkg::req_t req_w;
  fos_pkg::req_t req_q;
  logic          req_empty;
  logic          req_pop;
  fos_pkg::res_t res_w;
  fos_pkg::res_t res_q;
  logic          res_valid;
  logic          res_full;

  // Pack the request word
  assign req_w.req_type       = req_type;
  assign req_w.push_value     = push_value;
  assign req_w.prev_mean_wait = prev_mean_wait;
  assign req_w.max_wait_floor = max_wait_floor;
  assign req_w.now_time       = now_time;

  fos_queue #(.W($bits(fos_pkg::req_t))) u_reqq (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (req_w),
    .full  (full),
    .pop   (req_pop),
    .dout  (req_q),
    .empty (req_empty)
  );

  fos_engine #(.DEPTH(DEPTH)) u_engine (
    .clk       (clk),
    .rst       (rst),
    .req_in    (req_q),
    .req_empty (req_empty),
    .req_pop   (req_pop),
    .res_full  (res_full),
    .res       (res_w),
    .res_valid (res_valid)
  );

  fos_queue #(.W($bits(fos_pkg::res_t))) u_resq (
    .clk   (clk),
    .rst   (rst),
    .push  (res_valid),
    .din   (res_w),
    .full  (res_full),
    .pop   (pop),
    .dout  (res_q),
    .empty (empty)
  );

  // Unpack the result word
  assign status          = res_q.status;
  assign popped_value    = res_q.popped_value;
  assign entry_count     = res_q.entry_count;
  assign max_value       = res_q.max_value;
  assign mean_value      = res_q.mean_value;
  assign median_value    = res_q.median_value;
  assign max_wait_units  = res_q.max_wait_units;
  assign mean_wait_units = res_q.mean_wait_units;

`ifndef SYNTHESIS
  // A result never arrives at a full result queue
  assert property (@(posedge clk) disable iff (rst) res_valid |-> !res_full)
    else $error("result dropped at full result queue");

  // An empty pop reports the -1 marker
  assert property (@(posedge clk) disable iff (rst)
    (!empty && (status == fos_pkg::ST_POP_EMPTY)) |-> (popped_value == -32'sd1))
    else $error("empty pop without marker");

  // A dropped push reports a full store
  assert property (@(posedge clk) disable iff (rst)
    (!empty && (status == fos_pkg::ST_FULL)) |-> (entry_count == 7'(DEPTH)))
    else $error("push dropped below capacity");
`endif

endmodule
`default_nettype wire

[design/fos_queue.sv]
`default_nettype none
module fos_queue #(
  parameter int W = 8
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  wire logic [W-1:0] din,
  output logic              full,
  input  wire logic         pop,
  output logic [W-1:0]      dout,
  output logic              empty
);

  logic [W-1:0] slot [2];
  logic         wp;
  logic         rp;
  logic [1:0]   cnt;
  logic         do_push;
  logic         do_pop;

  assign full    = (cnt == 2'd2);
  assign empty   = (cnt == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = slot[rp];

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (do_push) wp <= ~wp;
      if (do_pop) rp <= ~rp;
      cnt <= cnt + 2'(do_push) - 2'(do_pop);
    end
  end

  // Hold the word
  always_ff @(posedge clk) begin
    if (do_push) slot[wp] <= din;
  end

endmodule
`default_nettype wire

[design/fos_div.sv]
`default_nettype none
module fos_div #(
  parameter int DW = 40,
  parameter int VW = 10
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [DW-1:0] dividend,
  input  wire logic [VW-1:0] divisor,
  output logic               done,
  output logic [DW-1:0]      quotient
);

  localparam int NW = $clog2(DW + 1);

  logic [DW-1:0] quo;
  logic [VW-1:0] rem;
  logic [VW-1:0] dsr;
  logic [NW-1:0] cnt;
  logic [VW:0]   sh;
  logic          ge;

  // One quotient bit per cycle, restoring
  assign sh       = {rem, quo[DW-1]};
  assign ge       = (sh >= {1'b0, dsr});
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= NW'(DW);
      end else if (cnt != '0) begin
        cnt  <= cnt - NW'(1);
        done <= (cnt == NW'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (cnt != '0) begin
      rem <= ge ? VW'(sh - {1'b0, dsr}) : sh[VW-1:0];
      quo <= {quo[DW-2:0], ge};
    end
  end

endmodule
`default_nettype wire

[design/fos_engine.sv]
`default_nettype none
module fos_engine #(
  parameter int DEPTH = fos_pkg::DEPTH_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire fos_pkg::req_t req_in,
  input  wire logic          req_empty,
  output logic               req_pop,
  input  wire logic          res_full,
  output fos_pkg::res_t      res,
  output logic               res_valid
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int DW = 33 + CW;
  localparam int VW = CW;

  typedef enum logic [3:0] {
    S_IDLE, S_POP_RD, S_POP_TAKE, S_SUM, S_MEAN_DIV, S_MED_LOAD, S_MED_GRAB,
    S_MED_SCAN, S_WSWEEP, S_WDIV_CUR, S_WHALF, S_WSCALE
  } state_t;

  state_t               state;
  fos_pkg::req_t        req;
  logic [AW-1:0]        head;
  logic [CW-1:0]        count;
  logic [AW-1:0]        ptr;
  logic [AW-1:0]        cptr;
  logic [CW-1:0]        j;
  logic [CW-1:0]        i;
  logic                 dv;
  logic [30:0]          store [DEPTH];
  logic [30:0]          rd_data;
  logic [30+CW:0]       sum_u;
  logic [30:0]          mx;
  logic [30:0]          mean;
  logic [30:0]          cand;
  logic [CW-1:0]        cnt_lt;
  logic [CW-1:0]        cnt_le;
  logic [30:0]          med_lo;
  logic [30:0]          med_hi;
  logic signed [31+CW:0] wsum;
  logic signed [31:0]   best;
  logic signed [32:0]   cur;
  logic [31:0]          half;
  logic                 tneg;
  logic                 div_start;
  logic [DW-1:0]        div_dividend;
  logic [VW-1:0]        div_divisor;
  logic                 div_done;
  logic [DW-1:0]        div_q;

  logic                 take;
  logic                 we;
  logic [AW:0]          tail_sum;
  logic [AW-1:0]        tail;
  logic signed [31:0]   d;
  logic [31+CW:0]       wmag;
  logic signed [33:0]   t;
  logic [33:0]          tmag;
  logic [CW-1:0]        k1;
  logic [CW-1:0]        k2;
  logic [30:0]          lo_n;
  logic [30:0]          hi_n;
  logic [32:0]          med_sum;
  logic [22:0]          q23;
  logic                 sweep_end;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  // Scale a non-negative wait by the wait unit through a reciprocal multiply
  function automatic logic [31:0] div_unit(input logic [31:0] x);
    logic [63:0] prod;
    prod = 64'(x) * 64'(fos_pkg::WAIT_RECIP);
    return 32'(prod >> fos_pkg::WAIT_SHIFT);
  endfunction

  // Take a word when idle and the result side has room, including the word being written
  assign take    = (state == S_IDLE) && !req_empty && !res_full && !res_valid;
  assign req_pop = take;
  assign we      = take && (req_in.req_type == fos_pkg::REQ_PUSH) &&
                   (count != CW'(DEPTH));

  assign tail_sum = (AW+1)'(head) + (AW+1)'(count);
  assign tail     = (tail_sum >= (AW+1)'(DEPTH)) ? AW'(tail_sum - (AW+1)'(DEPTH))
                                                 : tail_sum[AW-1:0];

  // Wait of the entry on the read port
  assign d    = $signed({1'b0, req.now_time}) - $signed({1'b0, rd_data});
  assign wmag = wsum[31+CW] ? (32+CW)'(-wsum) : (32+CW)'(wsum);
  assign t    = {cur[32], cur} + {{2{req.prev_mean_wait[31]}}, req.prev_mean_wait};
  assign tmag = t[33] ? 34'(-t) : 34'(t);
  assign q23  = 23'(div_unit(half));

  // Median ranks
  assign k2 = count >> 1;
  assign k1 = count[0] ? k2 : k2 - CW'(1);
  assign lo_n = ((cnt_lt <= k1) && (k1 < cnt_le)) ? cand : med_lo;
  assign hi_n = ((cnt_lt <= k2) && (k2 < cnt_le)) ? cand : med_hi;
  assign med_sum = {2'b00, lo_n} + {2'b00, hi_n};

  assign sweep_end = (j == count) && !dv;

  // Entry memory, registered read
  always_ff @(posedge clk) begin
    if (we) store[tail] <= req_in.push_value;
    rd_data <= store[ptr];
  end

  fos_div #(.DW(DW), .VW(VW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      count     <= '0;
      res_valid <= 1'b0;
      div_start <= 1'b0;
      dv        <= 1'b0;
    end else begin
      res_valid <= 1'b0;
      div_start <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (take) begin
            req <= req_in;
            ptr <= head;
            j   <= '0;
            dv  <= 1'b0;
            case (req_in.req_type)
              fos_pkg::REQ_PUSH: begin
                res_valid <= 1'b1;
                if (count == CW'(DEPTH)) begin
                  res <= '{status: fos_pkg::ST_FULL, entry_count: 7'(count), default: '0};
                end else begin
                  count <= count + CW'(1);
                  res   <= '{entry_count: 7'(count + CW'(1)), default: '0};
                end
              end
              fos_pkg::REQ_POP: begin
                if (count == '0) begin
                  res_valid <= 1'b1;
                  res       <= '{status: fos_pkg::ST_POP_EMPTY,
                                 popped_value: {32{1'b1}}, default: '0};
                end else begin
                  res   <= '0;
                  state <= S_POP_RD;
                end
              end
              fos_pkg::REQ_STATS: begin
                res <= '0;
                if (count == '0) begin
                  res_valid <= 1'b1;
                end else begin
                  sum_u <= '0;
                  mx    <= '0;
                  state <= S_SUM;
                end
              end
              default: begin
                res   <= '0;
                wsum  <= '0;
                best  <= $signed({1'b0, req_in.max_wait_floor});
                state <= S_WSWEEP;
              end
            endcase
          end
        end
        S_POP_RD: state <= S_POP_TAKE;
        S_POP_TAKE: begin
          res.popped_value <= {1'b0, rd_data};
          res.entry_count  <= 7'(count - CW'(1));
          head             <= wrap_inc(head);
          count            <= count - CW'(1);
          res_valid        <= 1'b1;
          state            <= S_IDLE;
        end
        S_SUM: begin
          if (j != count) begin
            ptr <= wrap_inc(ptr);
            j   <= j + CW'(1);
            dv  <= 1'b1;
          end else begin
            dv <= 1'b0;
          end
          if (dv) begin
            sum_u <= sum_u + (31+CW)'(rd_data);
            if (rd_data > mx) mx <= rd_data;
          end
          if (sweep_end) begin
            div_start    <= 1'b1;
            div_dividend <= DW'(sum_u);
            div_divisor  <= VW'(count);
            state        <= S_MEAN_DIV;
          end
        end
        S_MEAN_DIV: begin
          if (div_done) begin
            mean  <= div_q[30:0];
            cptr  <= head;
            ptr   <= head;
            i     <= '0;
            state <= S_MED_LOAD;
          end
        end
        S_MED_LOAD: state <= S_MED_GRAB;
        S_MED_GRAB: begin
          cand   <= rd_data;
          cptr   <= wrap_inc(cptr);
          ptr    <= head;
          j      <= '0;
          dv     <= 1'b0;
          cnt_lt <= '0;
          cnt_le <= '0;
          state  <= S_MED_SCAN;
        end
        S_MED_SCAN: begin
          if (j != count) begin
            ptr <= wrap_inc(ptr);
            j   <= j + CW'(1);
            dv  <= 1'b1;
          end else begin
            dv <= 1'b0;
          end
          if (dv) begin
            cnt_lt <= cnt_lt + CW'(rd_data < cand);
            cnt_le <= cnt_le + CW'(rd_data <= cand);
          end
          if (sweep_end) begin
            med_lo <= lo_n;
            med_hi <= hi_n;
            i      <= i + CW'(1);
            if (i == count - CW'(1)) begin
              res.entry_count  <= 7'(count);
              res.max_value    <= mx;
              res.mean_value   <= mean;
              res.median_value <= med_sum[31:1];
              res_valid        <= 1'b1;
              state            <= S_IDLE;
            end else begin
              ptr   <= cptr;
              state <= S_MED_LOAD;
            end
          end
        end
        S_WSWEEP: begin
          if (j != count) begin
            ptr <= wrap_inc(ptr);
            j   <= j + CW'(1);
            dv  <= 1'b1;
          end else begin
            dv <= 1'b0;
          end
          if (dv) begin
            wsum <= wsum + (32+CW)'(d);
            if (d > best) best <= d;
          end
          if (sweep_end) begin
            if (count == '0) begin
              cur   <= '0;
              state <= S_WHALF;
            end else begin
              div_start    <= 1'b1;
              div_dividend <= DW'(wmag);
              div_divisor  <= VW'(count);
              state        <= S_WDIV_CUR;
            end
          end
        end
        S_WDIV_CUR: begin
          if (div_done) begin
            cur   <= wsum[31+CW] ? -33'(div_q) : 33'(div_q);
            state <= S_WHALF;
          end
        end
        // Halve the combined mean, keeping its sign apart
        S_WHALF: begin
          tneg  <= t[33];
          half  <= 32'(tmag >> 1);
          state <= S_WSCALE;
        end
        S_WSCALE: begin
          res.entry_count     <= 7'(count);
          res.max_wait_units  <= 22'(div_unit(best));
          res.mean_wait_units <= tneg ? -q23 : q23;
          res_valid           <= 1'b1;
          state               <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire
